### rtl/core/tli_pkg.sv
// Shared constants and types for the table linear interpolator.
package tli_pkg;

    // Table geometry
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // Data widths (Q16.16 values and derived arithmetic)
    localparam int DATA_W     = 32;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = DATA_W + 2;
    localparam int STEP_W     = $clog2(PROD_W);

    // Item kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_FEW    = 3'd2,
        ST_STORED = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // Handshake between the controller and the serial divider
    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

### rtl/core/tli_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module tli_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [tli_pkg::PROD_W-1:0]        dividend,
    input  logic [tli_pkg::DATA_W-1:0]        divisor,
    output logic                              done,
    output logic [tli_pkg::PROD_W-1:0]        quotient
);
    import tli_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [DATA_W-1:0]   div_reg;

    logic [DATA_W:0]     trial;
    logic                fits;
    logic [DATA_W:0]     trial_sub;

    // One restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        fits      = (trial >= {1'b0, div_reg});
        trial_sub = trial - {1'b0, div_reg};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            // done pulses for one cycle after the last step
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(PROD_W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(PROD_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: dividend shifts out the top while quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/table_linear_interpolator.sv
// Append: the accepted beat goes to S_OUT, which loads the output register once
//   it is free; one item at a time. Query: the result waits on the table scan,
//   one entry per cycle over the single read port, and the 64-step serial divider.
// The next item is accepted as soon as the previous result is loaded into the
//   output register. Reset clears the point count and output valid; the
//   table contents are undefined until written and need no clearing pass.
module table_linear_interpolator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic                              s_restart,
    input  logic signed [tli_pkg::DATA_W-1:0] s_point_x,
    input  logic signed [tli_pkg::DATA_W-1:0] s_point_y,
    input  logic signed [tli_pkg::DATA_W-1:0] s_query_x,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [tli_pkg::DATA_W-1:0] m_result_y,
    output tli_pkg::status_t                  m_status
);
    import tli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_LAST,
        S_CHK_FIRST,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DSTART,
        S_DWAIT,
        S_FIN,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ADDR_W-1:0]        idx_reg;

    // Table memories
    logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] rd_x_reg;
    logic signed [DATA_W-1:0] rd_y_reg;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;

    // Query working registers
    logic signed [DATA_W-1:0] q_reg;
    logic signed [DATA_W-1:0] xl_reg;
    logic signed [DATA_W-1:0] yl_reg;
    logic signed [DATA_W-1:0] xr_reg;
    logic signed [DATA_W-1:0] yr_reg;
    logic [DATA_W-1:0]        hm_reg;
    logic [DATA_W-1:0]        lm_reg;
    logic [DATA_W-1:0]        dm_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;

    // Pending and output result
    logic signed [DATA_W-1:0] res_y_reg;
    status_t                  res_st_reg;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_result_y_reg;
    status_t                  m_status_reg;

    // Divider
    div_ctl_t                 div_ctl;
    logic [PROD_W-1:0]        div_quo;

    // Accept and append decode
    logic                     s_fire;
    logic [CNT_W-1:0]         cnt_eff;
    logic                     tbl_full;
    logic [ADDR_W-1:0]        cnt_m1;
    logic                     out_free;

    // Segment arithmetic
    logic signed [DIFF_W-1:0] len_d;
    logic signed [DIFF_W-1:0] h_d;
    logic signed [DIFF_W-1:0] l1_d;
    logic [DIFF_W-1:0]        len_abs;
    logic [DIFF_W-1:0]        h_abs;
    logic [DIFF_W-1:0]        l1_abs;
    logic [DATA_W:0]          qm_sat;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] sum_sat;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign cnt_eff  = s_restart ? '0 : cnt_reg;
    assign tbl_full = (cnt_eff >= CNT_W'(MAX_POINTS));
    assign cnt_m1   = ADDR_W'(cnt_reg - CNT_W'(1));
    assign wr_en    = s_fire && (s_kind == KIND_APPEND) && !tbl_full;
    assign wr_addr  = cnt_eff[ADDR_W-1:0];

    // Read address: last entry, then first, then walk up the table
    always_comb begin
        case (state_reg)
            S_IDLE:      rd_addr = cnt_m1;
            S_CHK_LAST:  rd_addr = '0;
            S_CHK_FIRST: rd_addr = ADDR_W'(1);
            S_SCAN:      rd_addr = idx_reg + ADDR_W'(1);
            default:     rd_addr = '0;
        endcase
    end

    // Table memories: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            x_mem[wr_addr] <= s_point_x;
            y_mem[wr_addr] <= s_point_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    // Segment differences and their magnitudes (all below 2^32)
    always_comb begin
        len_d   = DIFF_W'(xr_reg) - DIFF_W'(xl_reg);
        h_d     = DIFF_W'(yr_reg) - DIFF_W'(yl_reg);
        l1_d    = DIFF_W'(q_reg)  - DIFF_W'(xl_reg);
        len_abs = len_d[DIFF_W-1] ? DIFF_W'(-len_d) : DIFF_W'(len_d);
        h_abs   = h_d[DIFF_W-1]   ? DIFF_W'(-h_d)   : DIFF_W'(h_d);
        l1_abs  = l1_d[DIFF_W-1]  ? DIFF_W'(-l1_d)  : DIFF_W'(l1_d);
    end

    // Clamp the quotient to 2^32, apply the sign, saturate to 32 bits
    always_comb begin
        if (|div_quo[PROD_W-1:DATA_W+1] || (div_quo[DATA_W] && |div_quo[DATA_W-1:0])) begin
            qm_sat = {1'b1, {DATA_W{1'b0}}};
        end else begin
            qm_sat = div_quo[DATA_W:0];
        end
        if (neg_reg) begin
            sum = SUM_W'(yl_reg) - $signed({1'b0, qm_sat});
        end else begin
            sum = SUM_W'(yl_reg) + $signed({1'b0, qm_sat});
        end
        if (sum > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
            sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (sum < -SUM_W'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}}))) begin
            sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sum_sat = sum[DATA_W-1:0];
        end
    end

    assign div_ctl.start = (state_reg == S_DSTART);

    tli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .dividend (prod_reg),
        .divisor  (dm_reg),
        .done     (div_ctl.done),
        .quotient (div_quo)
    );

    // Controller, working registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // S_OUT reloads the output register itself when it is taken
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        q_reg     <= s_query_x;
                        res_y_reg <= '0;
                        if (s_kind == KIND_APPEND) begin
                            state_reg <= S_OUT;
                            if (tbl_full) begin
                                cnt_reg    <= cnt_eff;
                                res_st_reg <= ST_FULL;
                            end else begin
                                cnt_reg    <= cnt_eff + CNT_W'(1);
                                res_st_reg <= ST_STORED;
                            end
                        end else if (cnt_reg < CNT_W'(2)) begin
                            res_st_reg <= ST_FEW;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_CHK_LAST;
                        end
                    end
                end
                S_CHK_LAST: begin
                    if (q_reg > rd_x_reg) begin
                        res_st_reg <= ST_RANGE;
                        state_reg  <= S_OUT;
                    end else begin
                        state_reg  <= S_CHK_FIRST;
                    end
                end
                S_CHK_FIRST: begin
                    if (q_reg < rd_x_reg) begin
                        res_st_reg <= ST_RANGE;
                        state_reg  <= S_OUT;
                    end else begin
                        xl_reg    <= rd_x_reg;
                        yl_reg    <= rd_y_reg;
                        idx_reg   <= ADDR_W'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // First segment with xl <= q <= xr wins
                    if (q_reg >= xl_reg && q_reg <= rd_x_reg) begin
                        xr_reg    <= rd_x_reg;
                        yr_reg    <= rd_y_reg;
                        state_reg <= S_PREP;
                    end else if (idx_reg == cnt_m1) begin
                        res_st_reg <= ST_RANGE;
                        state_reg  <= S_OUT;
                    end else begin
                        xl_reg  <= rd_x_reg;
                        yl_reg  <= rd_y_reg;
                        idx_reg <= idx_reg + ADDR_W'(1);
                    end
                end
                S_PREP: begin
                    if (len_d == '0) begin
                        res_y_reg  <= yl_reg;
                        res_st_reg <= ST_OK;
                        state_reg  <= S_OUT;
                    end else begin
                        hm_reg    <= h_abs[DATA_W-1:0];
                        lm_reg    <= l1_abs[DATA_W-1:0];
                        dm_reg    <= len_abs[DATA_W-1:0];
                        neg_reg   <= h_d[DIFF_W-1] ^ l1_d[DIFF_W-1] ^ len_d[DIFF_W-1];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= hm_reg * lm_reg;
                    state_reg <= S_DSTART;
                end
                S_DSTART: begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_ctl.done) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    res_y_reg  <= sum_sat;
                    res_st_reg <= ST_OK;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_result_y_reg <= res_y_reg;
                        m_status_reg   <= res_st_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_result_y = m_result_y_reg;
    assign m_status   = m_status_reg;

endmodule
